/* rtl/core/gccc_pkg.sv */
// gccc_pkg: shared widths and reset constants for the loop cover counter
// used by the top level and by its port checker; no dependencies

package gccc_pkg;

   // column count register
   localparam int CSR_BITS = 4;
   localparam logic [CSR_BITS-1:0] COLUMN_COUNT_RESET = 4'd12;

   // stream payload widths, padded to whole bytes
   localparam int REQ_TDATA_BITS = 8;
   localparam int RSP_TDATA_BITS = 64;

endpackage

/* rtl/core/gccc_bank.sv */
// gccc_bank: one bank of the count table, one write port and two read ports
// read data registered; no dependencies

module gccc_bank #(
   parameter int ADDR_BITS = 13,
   parameter int DATA_BITS = 64
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr_a,
   input  logic [ADDR_BITS-1:0] rd_addr_b,
   output logic [DATA_BITS-1:0] rd_data_a,
   output logic [DATA_BITS-1:0] rd_data_b
);

   localparam int DEPTH = 1 << ADDR_BITS;

   logic [DATA_BITS-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // two registered read ports
   always_ff @(posedge clock) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

/* rtl/core/grid_cycle_cover_count.sv */
// grid_cycle_cover_count: top level of the plug-mask loop cover counter
// depends on gccc_pkg and gccc_bank (two ping-pong table banks)
//
// Usage: grid cells stream in on req_ in row-major order, one beat per cell;
// req_tdata bit 0 is the open flag and req_tlast marks the final cell. After
// the final cell one beat leaves on rsp_ carrying the number of loop covers
// modulo 2^COUNT_BITS. csr_ writes the column count (1..MAX_COLUMNS, zero
// acts as one, larger acts as MAX_COLUMNS) and is taken only while idle.
// Operation: every cell sweeps the whole table, one mask per cycle, through the
// read ports of the current bank into the other bank. The first cell of a
// row runs a row shift sweep first. A final cell then hands the count to
// the output register. Reset clears control state only: a fresh flag makes
// the current bank read as one at mask zero and zero elsewhere until the
// next sweep overwrites it, so there is no clearing pass; the same flag
// restores the table after each final cell. req_tready is high while idle,
// also while a result waits on a stalled rsp_ side; a further final cell
// then holds until that beat leaves.

module grid_cycle_cover_count #(
   parameter int MAX_COLUMNS = 12,
   parameter int COUNT_BITS  = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   // cell input
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [gccc_pkg::REQ_TDATA_BITS-1:0] req_tdata, // [0] cell_open
   input  logic                               req_tlast,  // last_cell
   // count output
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [gccc_pkg::RSP_TDATA_BITS-1:0] rsp_tdata, // [63:0] way_count
   // column count register
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [gccc_pkg::CSR_BITS-1:0]       csr_data    // column_count
);

   localparam int AW = MAX_COLUMNS + 1;
   localparam int CW = $clog2(MAX_COLUMNS + 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SHIFT  = 3'd1;
   localparam logic [2:0] ST_UPDATE = 3'd2;
   localparam logic [2:0] ST_FLIP   = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [2:0]                   state_ff, state_in;
   logic [AW-1:0]                k_ff, k_in;
   logic                         sel_ff, sel_in;
   logic                         fresh_ff, fresh_in;
   logic [CW-1:0]                pos_ff, pos_in;
   logic [CW-1:0]                pos_cur_ff, pos_cur_in;
   logic                         open_ff, open_in;
   logic                         last_ff, last_in;
   logic [gccc_pkg::CSR_BITS-1:0] column_count_ff, column_count_in;
   logic                         pipe_valid_ff, pipe_valid_in;
   logic [AW-1:0]                pipe_k_ff, pipe_k_in;
   logic                         pipe_shift_ff, pipe_shift_in;
   logic [COUNT_BITS-1:0]        result_ff, result_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [COUNT_BITS-1:0]        rsp_data_ff, rsp_data_in;

   logic [CW-1:0]         m_active;
   logic [AW:0]           span;
   logic [AW-1:0]         left_bit, up_bit;
   logic [AW-1:0]         rd_addr_a, rd_addr_b;
   logic [COUNT_BITS-1:0] bank0_a, bank0_b, bank1_a, bank1_b;
   logic [COUNT_BITS-1:0] cur_a, cur_b, wr_val;
   logic                  a_zero, b_zero, in_span, plug_a, plug_b;
   logic [CW-1:0]         pos_eff;
   logic [CW:0]           pos_inc;

   // clamp the column count into 1..MAX_COLUMNS
   always_comb begin
      if (column_count_ff == '0) begin
         m_active = CW'(1);
      end else if (column_count_ff > gccc_pkg::CSR_BITS'(MAX_COLUMNS)) begin
         m_active = CW'(MAX_COLUMNS);
      end else begin
         m_active = CW'(column_count_ff);
      end
   end

   assign span     = (AW+1)'(1) << ((CW+1)'(m_active) + (CW+1)'(1));
   assign left_bit = AW'(1) << pos_cur_ff;
   assign up_bit   = left_bit << 1;

   // read addresses for the mask being issued
   assign rd_addr_a = (state_ff == ST_SHIFT) ? (k_ff >> 1) : k_ff;
   assign rd_addr_b = k_ff ^ left_bit ^ up_bit;

   gccc_bank #(.ADDR_BITS(AW), .DATA_BITS(COUNT_BITS)) u_bank0 (
      .clock     (clock),
      .wr_en     (pipe_valid_ff && sel_ff),
      .wr_addr   (pipe_k_ff),
      .wr_data   (wr_val),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (bank0_a),
      .rd_data_b (bank0_b)
   );

   gccc_bank #(.ADDR_BITS(AW), .DATA_BITS(COUNT_BITS)) u_bank1 (
      .clock     (clock),
      .wr_en     (pipe_valid_ff && !sel_ff),
      .wr_addr   (pipe_k_ff),
      .wr_data   (wr_val),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (bank1_a),
      .rd_data_b (bank1_b)
   );

   // current table value, with the fresh table standing in after a clear
   assign a_zero = pipe_shift_ff ? (pipe_k_ff[AW-1:1] == '0) : (pipe_k_ff == '0);
   assign b_zero = ((pipe_k_ff ^ left_bit ^ up_bit) == '0);
   assign cur_a  = fresh_ff ? COUNT_BITS'(a_zero) : (sel_ff ? bank1_a : bank0_a);
   assign cur_b  = fresh_ff ? COUNT_BITS'(b_zero) : (sel_ff ? bank1_b : bank0_b);

   // new value of the mask in the write stage
   assign in_span = ({1'b0, pipe_k_ff} < span);
   assign plug_a  = |(pipe_k_ff & left_bit);
   assign plug_b  = |(pipe_k_ff & up_bit);

   always_comb begin
      wr_val = '0;
      if (pipe_shift_ff) begin
         if (!pipe_k_ff[0] && in_span) begin
            wr_val = cur_a;
         end
      end else if (in_span) begin
         if (open_ff) begin
            wr_val = ((plug_a != plug_b) ? cur_a : '0) + cur_b;
         end else if (!plug_a && !plug_b) begin
            wr_val = cur_a;
         end
      end
   end

   assign pos_eff = (pos_ff >= m_active) ? '0 : pos_ff;
   assign pos_inc = (CW+1)'(pos_cur_ff) + (CW+1)'(1);

   // sequencer: accept, sweep, bank flip, result handoff
   always_comb begin
      state_in        = state_ff;
      k_in            = k_ff;
      sel_in          = sel_ff;
      fresh_in        = fresh_ff;
      pos_in          = pos_ff;
      pos_cur_in      = pos_cur_ff;
      open_in         = open_ff;
      last_in         = last_ff;
      column_count_in = column_count_ff;
      pipe_valid_in   = 1'b0;
      pipe_k_in       = k_ff;
      pipe_shift_in   = (state_ff == ST_SHIFT);
      result_in       = result_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_data_in     = rsp_data_ff;

      // output beat leaves
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // count at mask zero after the cell update
      if (pipe_valid_ff && !pipe_shift_ff && (pipe_k_ff == '0)) begin
         result_in = wr_val;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (csr_valid) begin
               column_count_in = csr_data;
            end
            if (req_tvalid) begin
               pos_cur_in = pos_eff;
               open_in    = req_tdata[0];
               last_in    = req_tlast;
               k_in       = '0;
               state_in   = (pos_eff == '0) ? ST_SHIFT : ST_UPDATE;
            end
         end
         ST_SHIFT, ST_UPDATE: begin
            pipe_valid_in = 1'b1;
            k_in          = k_ff + AW'(1);
            if (k_ff == '1) begin
               state_in = ST_FLIP;
            end
         end
         ST_FLIP: begin
            sel_in   = !sel_ff;
            fresh_in = 1'b0;
            if (pipe_shift_ff) begin
               k_in     = '0;
               state_in = ST_UPDATE;
            end else begin
               pos_in   = (pos_inc >= (CW+1)'(m_active)) ? '0 : pos_inc[CW-1:0];
               state_in = last_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result_ff;
               fresh_in     = 1'b1;
               pos_in       = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         sel_ff          <= 1'b0;
         fresh_ff        <= 1'b1;
         pos_ff          <= '0;
         column_count_ff <= gccc_pkg::COLUMN_COUNT_RESET;
         pipe_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         sel_ff          <= sel_in;
         fresh_ff        <= fresh_in;
         pos_ff          <= pos_in;
         column_count_ff <= column_count_in;
         pipe_valid_ff   <= pipe_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      k_ff          <= k_in;
      pos_cur_ff    <= pos_cur_in;
      open_ff       <= open_in;
      last_ff       <= last_in;
      pipe_k_ff     <= pipe_k_in;
      pipe_shift_ff <= pipe_shift_in;
      result_ff     <= result_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = gccc_pkg::RSP_TDATA_BITS'(rsp_data_ff);

endmodule

/* rtl/core/gccc_checker.sv */
// gccc_checker: port-level assertions for grid_cycle_cover_count
// depends on gccc_pkg; bound to the top level at the end of this file

module gccc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [gccc_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   input logic                                req_tlast,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [gccc_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   input logic                                csr_valid,
   input logic                                csr_ready,
   input logic [gccc_pkg::CSR_BITS-1:0]       csr_data
);

   // a stalled output beat holds its count
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled rsp beat changed");

   // an accepted cell starts a sweep, so the input closes
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req still ready right after a cell beat");

   // a count appears only as the block returns to idle
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready && csr_ready)
      else $error("rsp beat rose while busy");

   // no count right after a cell beat
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("rsp beat rose one cycle after a cell beat");

   // nothing leaves straight out of reset
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp beat valid after reset");

endmodule

bind grid_cycle_cover_count gccc_checker u_gccc_checker (.*);

/* tb/grid_cycle_cover_count_test.sv */
// grid_cycle_cover_count_test: self-checking bench for the loop cover counter,
// keeps its own plug-mask table per cell and checks every count beat
// depends on gccc_pkg and the grid_cycle_cover_count top level

class loop_cover_board #(parameter int MAX_COLUMNS = 12, parameter int COUNT_BITS = 64);
   localparam int DEPTH = 1 << (MAX_COLUMNS + 1);
   localparam logic [63:0] COUNT_MASK = {64{1'b1}} >> (64 - COUNT_BITS);

   logic [63:0] ways_by_mask [DEPTH];
   logic [63:0] ways_scratch [DEPTH];
   int unsigned column;
   logic [gccc_pkg::CSR_BITS-1:0] column_reg;
   logic [63:0] awaited_counts [$];
   int unsigned failures;
   int unsigned reported;

   function new();
      column_reg = gccc_pkg::COLUMN_COUNT_RESET;
      failures = 0;
      reported = 0;
      clear_plane();
   endfunction

   // one way at the empty mask, none elsewhere, back to column zero
   function void clear_plane();
      for (int k = 0; k < DEPTH; k++) ways_by_mask[k] = '0;
      ways_by_mask[0] = 64'd1;
      column = 0;
   endfunction

   function void set_columns(logic [gccc_pkg::CSR_BITS-1:0] value);
      column_reg = value;
   endfunction

   function int unsigned pending();
      return awaited_counts.size();
   endfunction

   // advance the table by one accepted cell
   function void note_cell(bit open, bit last);
      int unsigned m;
      int unsigned span;
      int unsigned left;
      int unsigned up;
      bit a;
      bit b;
      logic [63:0] v;
      m = (column_reg == 0) ? 1 : ((column_reg > MAX_COLUMNS) ? MAX_COLUMNS : column_reg);
      span = 1 << (m + 1);
      if (column >= m) column = 0;

      // row start: shift row-end masks up by one, drop the top plug
      if (column == 0) begin
         for (int k = 0; k < DEPTH; k++) ways_scratch[k] = '0;
         for (int k = 0; k < (1 << m); k++) ways_scratch[k << 1] = ways_by_mask[k];
         ways_by_mask = ways_scratch;
      end

      // cell transition over the active masks
      left = 1 << column;
      up = 1 << (column + 1);
      for (int k = 0; k < DEPTH; k++) begin
         v = '0;
         if (k < span) begin
            a = (k & left) != 0;
            b = (k & up) != 0;
            if (open) begin
               if (a != b) v = ways_by_mask[k];
               v = v + ways_by_mask[(k ^ left ^ up) & (DEPTH - 1)];
            end else if (!a && !b) begin
               v = ways_by_mask[k];
            end
         end
         ways_scratch[k] = v & COUNT_MASK;
      end
      ways_by_mask = ways_scratch;

      column++;
      if (column >= m) column = 0;

      if (last) begin
         awaited_counts.push_back(ways_by_mask[0] & COUNT_MASK);
         clear_plane();
      end
   endfunction

   // compare one count beat with the oldest expectation
   function void check_count(logic [63:0] got);
      logic [63:0] want;
      if (awaited_counts.size() == 0) begin
         failures++;
         if (reported < 10) begin
            reported++;
            $display("unexpected way_count beat: got %0d", got);
         end
         return;
      end
      want = awaited_counts.pop_front();
      if (got !== want) begin
         failures++;
         if (reported < 10) begin
            reported++;
            $display("way_count mismatch: expected %0d, got %0d", want, got);
         end
      end
   endfunction

   function void finish_check();
      if (awaited_counts.size() != 0) begin
         failures += awaited_counts.size();
         $display("%0d way_count beats never arrived", awaited_counts.size());
      end
   endfunction
endclass

module grid_cycle_cover_count_test;

   localparam int MAX_COLUMNS = 12;
   localparam int COUNT_BITS = 64;
   localparam int SWEEP = (1 << (MAX_COLUMNS + 1)) + 2;
   localparam int SETTLE = 2 * SWEEP + 64;
   localparam longint LIMIT_CYCLES = 20_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid;
   logic req_tready;
   logic [gccc_pkg::REQ_TDATA_BITS-1:0] req_tdata;  // [0] cell_open
   logic req_tlast;                                 // last_cell
   logic rsp_tvalid;
   logic rsp_tready;
   logic [gccc_pkg::RSP_TDATA_BITS-1:0] rsp_tdata;  // [63:0] way_count
   logic csr_valid;
   logic csr_ready;
   logic [gccc_pkg::CSR_BITS-1:0] csr_data;         // column_count

   loop_cover_board #(MAX_COLUMNS, COUNT_BITS) board;
   bit steady = 1'b0;
   bit trailing_cells = 1'b0;
   int unsigned sent_cells = 0;

   grid_cycle_cover_count #(
      .MAX_COLUMNS(MAX_COLUMNS),
      .COUNT_BITS (COUNT_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // clock, period 4
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // watchdog
   initial begin
      #(4 * LIMIT_CYCLES);
      $display("status: fail");
      $finish;
   end

   // sample every handshake at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) board.set_columns(csr_data);
         if (req_tvalid && req_tready) board.note_cell(req_tdata[0], req_tlast);
         if (rsp_tvalid && rsp_tready) board.check_count(rsp_tdata[63:0]);
      end
   end

   // result side backpressure
   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 9);
   end

   // one cell beat, with random idle cycles ahead of it
   task automatic send_cell(input bit open, input bit last);
      while (!steady && $urandom_range(99) < 9) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= gccc_pkg::REQ_TDATA_BITS'(open);
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      sent_cells++;
      trailing_cells = !last;
   endtask

   task automatic send_grid(input int cells, input int open_pct, input bit close_grid);
      for (int i = 0; i < cells; i++)
         send_cell($urandom_range(99) < open_pct, close_grid && (i == cells - 1));
   endtask

   // hold the sender until every count is back and the table sweep is done
   task automatic drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (board.pending() != 0) @(negedge clock);
      if (trailing_cells) repeat (SETTLE) @(negedge clock);
      trailing_cells = 1'b0;
   endtask

   task automatic write_columns(input logic [gccc_pkg::CSR_BITS-1:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int unsigned iter;
      int unsigned cols;
      int unsigned m;
      int unsigned pick;
      board = new();
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset column count: single open cell, no cover
      send_cell(1'b1, 1'b1);
      // zero acts as one column
      write_columns(4'd0);
      send_cell(1'b1, 1'b0);
      send_cell(1'b1, 1'b1);
      send_cell(1'b0, 1'b1);
      write_columns(4'd1);
      send_cell(1'b1, 1'b1);
      // 2x2 fully open, then with an obstacle
      write_columns(4'd2);
      send_grid(4, 100, 1'b1);
      send_cell(1'b1, 1'b0);
      send_cell(1'b0, 1'b0);
      send_cell(1'b1, 1'b0);
      send_cell(1'b1, 1'b1);
      // last cell in the middle of a row
      send_cell(1'b1, 1'b0);
      send_cell(1'b1, 1'b0);
      send_cell(1'b1, 1'b1);
      // above the maximum acts as the maximum
      write_columns(4'd15);
      send_cell(1'b0, 1'b1);
      write_columns(4'd12);
      send_cell(1'b0, 1'b0);
      send_cell(1'b0, 1'b1);
      // column count shrinks under the position mid-row: next cell starts a row
      write_columns(4'd3);
      send_cell(1'b1, 1'b0);
      send_cell(1'b1, 1'b0);
      write_columns(4'd2);
      send_grid(4, 100, 1'b1);

      // random grids, mostly well formed
      iter = 0;
      while (sent_cells < 100) begin
         steady = (iter >= 6 && iter < 12);
         pick = $urandom_range(99);
         cols = (pick < 90) ? $urandom_range(0, 4) : $urandom_range(5, 15);
         write_columns(gccc_pkg::CSR_BITS'(cols));
         m = (cols == 0) ? 1 : ((cols > MAX_COLUMNS) ? MAX_COLUMNS : cols);
         pick = $urandom_range(99);
         if (pick < 80) begin
            send_grid(m * ((m <= 4) ? $urandom_range(1, 2) : 1), 85, 1'b1);
         end else if (pick < 90) begin
            send_grid($urandom_range(1, 2 * m), 50, 1'b1);
         end else begin
            // partial row with no last cell, the next setting may land mid-row
            send_grid($urandom_range(1, 3), 50, 1'b0);
         end
         iter++;
      end
      steady = 1'b0;

      drain();
      repeat (SETTLE) @(posedge clock);
      board.finish_check();
      if (board.failures == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule

/* files.f */
rtl/core/gccc_pkg.sv
rtl/core/gccc_bank.sv
rtl/core/grid_cycle_cover_count.sv
rtl/core/gccc_checker.sv
tb/grid_cycle_cover_count_test.sv
